// ===== rtl/stet_pkg.sv =====
// ----------------------------------------------------------------------------
// stet_pkg: shared definitions of the sorted two-level equation table
// Field widths, result codes, controller states and the cell control word.
// ----------------------------------------------------------------------------
package stet_pkg;

	localparam int ID_W             = 16;
	localparam int NUM_W            = 31;
	localparam int LEN_W            = 16;
	localparam int ENTRY_W          = NUM_W + LEN_W;
	localparam int DEF_MAX_PARTNERS = 16;
	localparam int DEF_MAX_EQUATIONS = 64;

	typedef enum logic [2:0] {
		ST_NEW_PARTNER    = 3'd0,
		ST_NEW_EQUATION   = 3'd1,
		ST_LENGTH_UPDATED = 3'd2,
		ST_PARTNERS_FULL  = 3'd3,
		ST_EQUATIONS_FULL = 3'd4
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FIND   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_SHIFT  = 7'b0010000,
		S_PUT    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic take_prev;
		logic take_new;
		logic inc;
	} cell_ctl_t;

endpackage

// ===== rtl/sorted_two_level_equation_table.sv =====
// ----------------------------------------------------------------------------
// sorted_two_level_equation_table: sorted partner list with equation lists
// Records (partner, equation, length) words in sorted, duplicate-free lists.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with partner_id, equation_number and
// equation_length. Output channel: out_valid/out_stall with status,
// partner_slot, equation_slot and equation_total; one result word per input.
// Partners live in a row of cells that compare the id in parallel and shift
// up by one cell on insert. Equations live in a single-port-read memory,
// one row per partner, searched and shifted one entry per cycle.
// Flow: a new partner or a full partner list passes S_FIND, S_DECIDE and
// S_DONE. A known partner also scans its n equations in S_SCAN; a new
// equation, unless the row is full, then shifts the entries above its
// position e up in S_SHIFT (none at the end) and is written in S_PUT.
// One word is in work at a time.
// A new word is accepted while a finished result still waits on out_stall.
// Reset empties the partner list; the equation memory is not cleared, as
// entries beyond a row's count are never read.
// ----------------------------------------------------------------------------
module sorted_two_level_equation_table
	import stet_pkg::*;
#(
	parameter int MAX_PARTNERS  = DEF_MAX_PARTNERS,
	parameter int MAX_EQUATIONS = DEF_MAX_EQUATIONS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ID_W-1:0]  partner_id,
	input  logic [NUM_W-1:0] equation_number,
	input  logic [LEN_W-1:0] equation_length,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [3:0]       partner_slot,
	output logic [5:0]       equation_slot,
	output logic [6:0]       equation_total
);

	localparam int RW    = (MAX_PARTNERS > 1) ? $clog2(MAX_PARTNERS) : 1;
	localparam int PCW   = $clog2(MAX_PARTNERS + 1);
	localparam int CW    = $clog2(MAX_EQUATIONS + 1);
	localparam int DEPTH = MAX_PARTNERS * MAX_EQUATIONS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0]  MAXE_A = AW'(MAX_EQUATIONS);
	localparam logic [PCW-1:0] MAXP_C = PCW'(MAX_PARTNERS);
	localparam logic [CW-1:0]  MAXE_C = CW'(MAX_EQUATIONS);

	state_t           st_q;
	logic [ID_W-1:0]  pid_q;
	logic [NUM_W-1:0] eqn_q;
	logic [LEN_W-1:0] len_q;
	logic [PCW-1:0]   ptot_q;
	logic [PCW-1:0]   p_q;
	logic             hit_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    tot_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    ltc_q;
	logic             match_q;
	logic             rd_v_s1;
	logic [CW-1:0]    wa_s1;

	logic [2:0] res_st_q;
	logic [3:0] res_ps_q;
	logic [5:0] res_es_q;
	logic [6:0] res_et_q;
	logic       out_v_q;
	logic [2:0] status_q;
	logic [3:0] pslot_q;
	logic [5:0] eslot_q;
	logic [6:0] etot_q;

	cell_ctl_t        ctl   [MAX_PARTNERS];
	logic [ID_W-1:0]  c_id  [MAX_PARTNERS];
	logic [RW-1:0]    c_row [MAX_PARTNERS];
	logic [CW-1:0]    c_tot [MAX_PARTNERS];
	logic [MAX_PARTNERS-1:0] c_lt;
	logic [MAX_PARTNERS-1:0] c_eq;

	logic [PCW-1:0]     p_find;
	logic               accept;
	logic               full_p;
	logic               do_ins;
	logic               scan_done;
	logic               re;
	logic [CW-1:0]      ridx;
	logic               we;
	logic [RW-1:0]      wrow;
	logic [CW-1:0]      widx;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic [NUM_W-1:0]   rnum;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (st_q != S_IDLE);
	assign full_p    = (ptot_q == MAXP_C);
	assign do_ins    = (st_q == S_DECIDE) && !hit_q && !full_p;
	assign scan_done = (st_q == S_SCAN) && (idx_q == tot_q) && !rd_v_s1;
	assign rnum      = rdata[ENTRY_W-1:LEN_W];

	for (genvar i = 0; i < MAX_PARTNERS; i++) begin : g_cell
		always_comb begin
			ctl[i].take_new  = do_ins && (PCW'(i) == p_q);
			ctl[i].take_prev = do_ins && (PCW'(i) > p_q);
			ctl[i].inc       = (st_q == S_PUT) && (PCW'(i) == p_q);
		end
		if (i == 0) begin : g_first
			stet_cell #(.RW(RW), .CW(CW)) u_cell (
				.clk(clk), .ctl(ctl[i]), .valid(PCW'(i) < ptot_q), .key(pid_q),
				.new_id(pid_q), .new_row(ptot_q[RW-1:0]),
				.prev_id(pid_q), .prev_row(ptot_q[RW-1:0]), .prev_total(CW'(1)),
				.id(c_id[i]), .row(c_row[i]), .total(c_tot[i]),
				.lt(c_lt[i]), .eq(c_eq[i])
			);
		end else begin : g_next
			stet_cell #(.RW(RW), .CW(CW)) u_cell (
				.clk(clk), .ctl(ctl[i]), .valid(PCW'(i) < ptot_q), .key(pid_q),
				.new_id(pid_q), .new_row(ptot_q[RW-1:0]),
				.prev_id(c_id[i-1]), .prev_row(c_row[i-1]), .prev_total(c_tot[i-1]),
				.id(c_id[i]), .row(c_row[i]), .total(c_tot[i]),
				.lt(c_lt[i]), .eq(c_eq[i])
			);
		end
	end

	always_comb begin
		p_find = MAXP_C;
		for (int i = MAX_PARTNERS - 1; i >= 0; i--) begin
			if (!c_lt[i]) begin
				p_find = PCW'(i);
			end
		end
	end

	always_comb begin
		re   = 1'b0;
		ridx = idx_q;
		if (st_q == S_SCAN) begin
			re = (idx_q < tot_q);
		end else if (st_q == S_SHIFT) begin
			re   = (idx_q > ltc_q);
			ridx = idx_q - CW'(1);
		end
	end

	always_comb begin
		we    = 1'b0;
		wrow  = row_q;
		widx  = ltc_q;
		wdata = {eqn_q, len_q};
		if (do_ins) begin
			we   = 1'b1;
			wrow = ptot_q[RW-1:0];
			widx = '0;
		end else if (scan_done && match_q) begin
			we = 1'b1;
		end else if ((st_q == S_SHIFT) && rd_v_s1) begin
			we    = 1'b1;
			widx  = wa_s1;
			wdata = rdata;
		end else if (st_q == S_PUT) begin
			we = 1'b1;
		end
	end

	stet_eqmem #(.DEPTH(DEPTH), .AW(AW)) u_eqmem (
		.clk(clk),
		.we(we),
		.waddr(AW'(wrow) * MAXE_A + AW'(widx)),
		.wdata(wdata),
		.re(re),
		.raddr(AW'(row_q) * MAXE_A + AW'(ridx)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			ptot_q  <= '0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= re;
			if ((st_q == S_DONE) && (!out_v_q || !out_stall)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						st_q <= S_FIND;
					end
				end
				S_FIND: begin
					st_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (hit_q) begin
						st_q <= S_SCAN;
					end else begin
						if (!full_p) begin
							ptot_q <= ptot_q + PCW'(1);
						end
						st_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						if (match_q || (tot_q == MAXE_C)) begin
							st_q <= S_DONE;
						end else begin
							st_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if ((idx_q == ltc_q) && !rd_v_s1) begin
						st_q <= S_PUT;
					end
				end
				S_PUT: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_v_q || !out_stall) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					pid_q <= partner_id;
					eqn_q <= equation_number;
					len_q <= equation_length;
				end
			end
			S_FIND: begin
				p_q   <= p_find;
				hit_q <= |c_eq;
			end
			S_DECIDE: begin
				row_q   <= c_row[p_q[RW-1:0]];
				tot_q   <= c_tot[p_q[RW-1:0]];
				idx_q   <= '0;
				ltc_q   <= '0;
				match_q <= 1'b0;
				if (!hit_q) begin
					if (full_p) begin
						res_st_q <= ST_PARTNERS_FULL;
						res_ps_q <= '0;
						res_es_q <= '0;
						res_et_q <= '0;
					end else begin
						res_st_q <= ST_NEW_PARTNER;
						res_ps_q <= 4'(p_q);
						res_es_q <= '0;
						res_et_q <= 7'd1;
					end
				end
			end
			S_SCAN: begin
				if (re) begin
					idx_q <= idx_q + CW'(1);
				end
				if (rd_v_s1) begin
					if (rnum < eqn_q) begin
						ltc_q <= ltc_q + CW'(1);
					end
					if (rnum == eqn_q) begin
						match_q <= 1'b1;
					end
				end
				if (scan_done) begin
					idx_q    <= tot_q;
					res_ps_q <= 4'(p_q);
					res_et_q <= 7'(tot_q);
					if (match_q) begin
						res_st_q <= ST_LENGTH_UPDATED;
						res_es_q <= 6'(ltc_q);
					end else begin
						res_st_q <= ST_EQUATIONS_FULL;
						res_es_q <= '0;
					end
				end
			end
			S_SHIFT: begin
				if (re) begin
					idx_q <= idx_q - CW'(1);
					wa_s1 <= idx_q;
				end
			end
			S_PUT: begin
				res_st_q <= ST_NEW_EQUATION;
				res_es_q <= 6'(ltc_q);
				res_et_q <= 7'(tot_q + CW'(1));
			end
			S_DONE: begin
				if (!out_v_q || !out_stall) begin
					status_q <= res_st_q;
					pslot_q  <= res_ps_q;
					eslot_q  <= res_es_q;
					etot_q   <= res_et_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_v_q;
	assign status         = status_q;
	assign partner_slot   = pslot_q;
	assign equation_slot  = eslot_q;
	assign equation_total = etot_q;

	a_ptot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptot_q <= MAXP_C)
		else $error("partner count beyond capacity");

	a_accept_find: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q == S_FIND))
		else $error("accepted word did not start a partner search");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> (ptot_q == $past(ptot_q) + PCW'(1)))
		else $error("partner insert did not raise the partner count");

	a_read_state: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> ((st_q == S_SCAN) || (st_q == S_SHIFT)))
		else $error("equation read data outside scan or shift");

endmodule

// ===== rtl/stet_cell.sv =====
// ----------------------------------------------------------------------------
// stet_cell: one partner cell
// Holds a partner id, its equation row and its equation count, compares the
// id with the search key and takes its lower neighbor's contents on insert.
// ----------------------------------------------------------------------------
module stet_cell
	import stet_pkg::*;
#(
	parameter int RW = 4,
	parameter int CW = 7
) (
	input  logic            clk,
	input  cell_ctl_t       ctl,
	input  logic            valid,
	input  logic [ID_W-1:0] key,
	input  logic [ID_W-1:0] new_id,
	input  logic [RW-1:0]   new_row,
	input  logic [ID_W-1:0] prev_id,
	input  logic [RW-1:0]   prev_row,
	input  logic [CW-1:0]   prev_total,
	output logic [ID_W-1:0] id,
	output logic [RW-1:0]   row,
	output logic [CW-1:0]   total,
	output logic            lt,
	output logic            eq
);

	logic [ID_W-1:0] id_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   total_q;

	always_ff @(posedge clk) begin
		if (ctl.take_new) begin
			id_q    <= new_id;
			row_q   <= new_row;
			total_q <= CW'(1);
		end else if (ctl.take_prev) begin
			id_q    <= prev_id;
			row_q   <= prev_row;
			total_q <= prev_total;
		end else if (ctl.inc) begin
			total_q <= total_q + CW'(1);
		end
	end

	assign id    = id_q;
	assign row   = row_q;
	assign total = total_q;
	assign lt    = valid && (id_q < key);
	assign eq    = valid && (id_q == key);

endmodule

// ===== rtl/stet_eqmem.sv =====
// ----------------------------------------------------------------------------
// stet_eqmem: equation store
// One row per partner; each entry holds an equation number and its length.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stet_eqmem
	import stet_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
